// ===== src/tbn_pkg.sv =====
// Shared types, codes and the microcode program of the tournament barrier node.
// No dependencies; used by the node top level and by its port checker.
package tbn_pkg;

    // Field and register widths fixed by the interface
    localparam int NODE_W  = 6;
    localparam int COUNT_W = 7;
    localparam int KIND_W  = 2;
    localparam int CFG_AW  = 1;
    localparam int CFG_DW  = 7;
    localparam int ROUND_W = 3;
    localparam int UPC_W   = 5;

    // Input mode codes
    localparam logic MODE_ARRIVE  = 1'b0;
    localparam logic MODE_MESSAGE = 1'b1;

    // Result kind codes
    localparam logic [KIND_W-1:0] KIND_SEND    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_AW-1:0] REG_NODE_ID    = 1'b0;
    localparam logic [CFG_AW-1:0] REG_NODE_COUNT = 1'b1;

    typedef logic [UPC_W-1:0] upc_t;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_ARRIVAL = 2'd1,
        PH_WAKEUP  = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ROLE_BYE,
        ROLE_WINNER,
        ROLE_LOSER,
        ROLE_CHAMPION
    } role_t;

    // Round counter operation
    typedef enum logic [1:0] {
        K_HOLD,
        K_INC,
        K_DEC,
        K_LOAD_R
    } kop_t;

    // Result emitted by a step
    typedef enum logic [2:0] {
        E_NONE,
        E_SEND_UP,
        E_SEND_DOWN,
        E_SEND_EXP,
        E_RELEASE,
        E_ERROR
    } emit_t;

    // Barrier state update
    typedef enum logic [1:0] {
        S_HOLD,
        S_PARK,
        S_LOSE,
        S_CLEAR
    } sop_t;

    // Jump conditions
    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_K_ZERO,
        C_K_GT_R,
        C_WIN,
        C_WAIT,
        C_LOSE,
        C_CHAMP
    } cond_t;

    typedef struct packed {
        kop_t  kop;
        emit_t emit;
        sop_t  sop;
        cond_t cond;
        upc_t  target;
        logic  done;
    } ucode_t;

    // Step addresses
    localparam upc_t U_IDLE      = 5'd0;
    localparam upc_t U_ERROR     = 5'd1;
    localparam upc_t U_ARRMSG    = 5'd2;
    localparam upc_t U_ARRNEXT   = 5'd3;
    localparam upc_t U_CHAMP     = 5'd4;
    localparam upc_t U_DESC      = 5'd5;
    localparam upc_t U_DESC_CHK  = 5'd6;
    localparam upc_t U_DESC_SKIP = 5'd7;
    localparam upc_t U_DESC_SEND = 5'd8;
    localparam upc_t U_RELEASE   = 5'd9;
    localparam upc_t U_CLIMB     = 5'd10;
    localparam upc_t U_CLIMB_WT  = 5'd11;
    localparam upc_t U_CLIMB_LS  = 5'd12;
    localparam upc_t U_CLIMB_NX  = 5'd13;
    localparam upc_t U_TOP       = 5'd14;
    localparam upc_t U_PARK      = 5'd15;
    localparam upc_t U_LOSE      = 5'd16;

    // Microcode program: one control word per step
    function automatic ucode_t ucode_rom(input upc_t addr);
        ucode_t w;
        w = '{kop: K_HOLD, emit: E_NONE, sop: S_HOLD, cond: C_NEXT,
              target: U_IDLE, done: 1'b0};
        case (addr)
            U_ERROR: begin
                w.emit = E_ERROR;
                w.done = 1'b1;
            end
            U_ARRMSG: begin
                w.cond   = C_CHAMP;
                w.target = U_CHAMP;
            end
            U_ARRNEXT: begin
                w.kop    = K_INC;
                w.cond   = C_ALWAYS;
                w.target = U_CLIMB;
            end
            U_CHAMP: begin
                w.emit = E_SEND_EXP;
                w.kop  = K_DEC;
            end
            U_DESC: begin
                w.cond   = C_K_ZERO;
                w.target = U_RELEASE;
            end
            U_DESC_CHK: begin
                w.cond   = C_WIN;
                w.target = U_DESC_SEND;
            end
            U_DESC_SKIP: begin
                w.kop    = K_DEC;
                w.cond   = C_ALWAYS;
                w.target = U_DESC;
            end
            U_DESC_SEND: begin
                w.emit   = E_SEND_UP;
                w.kop    = K_DEC;
                w.cond   = C_ALWAYS;
                w.target = U_DESC;
            end
            U_RELEASE: begin
                w.emit = E_RELEASE;
                w.sop  = S_CLEAR;
                w.done = 1'b1;
            end
            U_CLIMB: begin
                w.cond   = C_K_GT_R;
                w.target = U_TOP;
            end
            U_CLIMB_WT: begin
                w.cond   = C_WAIT;
                w.target = U_PARK;
            end
            U_CLIMB_LS: begin
                w.cond   = C_LOSE;
                w.target = U_LOSE;
            end
            U_CLIMB_NX: begin
                w.kop    = K_INC;
                w.cond   = C_ALWAYS;
                w.target = U_CLIMB;
            end
            U_TOP: begin
                w.kop    = K_LOAD_R;
                w.cond   = C_ALWAYS;
                w.target = U_DESC;
            end
            U_PARK: begin
                w.sop  = S_PARK;
                w.done = 1'b1;
            end
            U_LOSE: begin
                w.emit = E_SEND_DOWN;
                w.sop  = S_LOSE;
                w.done = 1'b1;
            end
            default: begin
                w.done = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== src/tournament_barrier_node.sv =====
// Top level of one tournament barrier node: microcoded round sequencer,
// role logic, barrier state and output register. Depends on tbn_pkg.
//
//  channel   direction  handshake           payload
//  s_        in         s_valid / s_ready   s_mode, s_source_node
//  m_        out        m_valid / m_ready   m_kind, m_peer_node, m_last
//  cfg_      in         cfg_wr_en           cfg_addr, cfg_wdata
//
// Each microcode step evaluates the role of one round. An item holds the
// sequencer from its acceptance until a step marked done returns it to idle.
// s_ready is high only while the sequencer sits at its idle step.
// A step that emits a word waits while the output register is full and m_ready
// is low. Reset (aresetn low, synchronous) returns the node to idle with
// node_id 0 and node_count 1.
module tournament_barrier_node #(
    parameter int MAX_NODES  = 64,
    parameter int MAX_ROUNDS = 6
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [tbn_pkg::CFG_AW-1:0]   cfg_addr,
    input  logic [tbn_pkg::CFG_DW-1:0]   cfg_wdata,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_mode,
    input  logic [tbn_pkg::NODE_W-1:0]   s_source_node,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [tbn_pkg::KIND_W-1:0]   m_kind,
    output logic [tbn_pkg::NODE_W-1:0]   m_peer_node,
    output logic                         m_last
);

    // Round counter must reach MAX_ROUNDS+1 and the stored round plus one
    localparam int KMAX = (MAX_ROUNDS + 1 > 8) ? MAX_ROUNDS + 1 : 8;
    localparam int KW   = $clog2(KMAX + 1);
    // Value width for 2^k, node sums and the clamped count
    localparam int VW   = (KMAX + 2 > 12) ? KMAX + 2 : 12;

    localparam int NW = tbn_pkg::NODE_W;
    localparam int RW = tbn_pkg::ROUND_W;

    // Configuration registers
    logic [NW-1:0]                node_id_reg;
    logic [tbn_pkg::COUNT_W-1:0]  node_count_reg;

    // Barrier state
    tbn_pkg::phase_t  phase_reg, phase_next;
    logic [RW-1:0]    round_reg, round_next;
    logic [NW-1:0]    exp_reg, exp_next;

    // Sequencer
    tbn_pkg::upc_t    upc_reg, upc_next;
    logic [KW-1:0]    k_reg, k_next;
    tbn_pkg::ucode_t  uw;

    // Output register
    logic                         out_valid_reg, out_valid_next;
    logic [tbn_pkg::KIND_W-1:0]   out_kind_reg, out_kind_next;
    logic [NW-1:0]                out_peer_reg, out_peer_next;
    logic                         out_last_reg, out_last_next;

    // Role datapath
    logic [VW-1:0]    n_eff;
    logic [KW-1:0]    rounds;
    logic [VW-1:0]    p_val, h_val, m_val, nid_ext, up_sum, down_diff;
    tbn_pkg::role_t   role;
    logic             cond_true;
    logic             slot_free;
    logic             step_go;
    logic             accept;
    logic             busy;
    logic [RW-1:0]    round_dec;

    // Clamp the count to 1..MAX_NODES
    always_comb begin
        n_eff = VW'(node_count_reg);
        if (node_count_reg == '0) begin
            n_eff = VW'(1);
        end else if (VW'(node_count_reg) > VW'(MAX_NODES)) begin
            n_eff = VW'(MAX_NODES);
        end
    end

    // Count rounds: powers of two below the count, capped at MAX_ROUNDS
    always_comb begin
        rounds = '0;
        for (int i = 0; i < MAX_ROUNDS; i++) begin
            if ((VW'(1) << i) < n_eff) begin
                rounds = rounds + KW'(1);
            end
        end
    end

    // Role of round k
    always_comb begin
        nid_ext   = VW'(node_id_reg);
        p_val     = VW'(1) << k_reg;
        h_val     = p_val >> 1;
        m_val     = nid_ext & (p_val - VW'(1));
        up_sum    = nid_ext + h_val;
        down_diff = nid_ext - h_val;
        if (node_id_reg == '0 && p_val >= n_eff) begin
            role = tbn_pkg::ROLE_CHAMPION;
        end else if (m_val == h_val) begin
            role = tbn_pkg::ROLE_LOSER;
        end else if (m_val == '0 && up_sum < n_eff && p_val < n_eff) begin
            role = tbn_pkg::ROLE_WINNER;
        end else begin
            role = tbn_pkg::ROLE_BYE;
        end
    end

    assign uw        = tbn_pkg::ucode_rom(upc_reg);
    assign slot_free = !out_valid_reg || m_ready;
    assign step_go   = (uw.emit == tbn_pkg::E_NONE) || slot_free;
    assign s_ready   = (upc_reg == tbn_pkg::U_IDLE);
    assign accept    = s_valid && s_ready;
    assign busy      = (phase_reg == tbn_pkg::PH_ARRIVAL) || (phase_reg == tbn_pkg::PH_WAKEUP);
    assign round_dec = (round_reg == '0) ? '0 : round_reg - RW'(1);

    // Evaluate the jump condition of the current step
    always_comb begin
        case (uw.cond)
            tbn_pkg::C_NEXT:   cond_true = 1'b0;
            tbn_pkg::C_ALWAYS: cond_true = 1'b1;
            tbn_pkg::C_K_ZERO: cond_true = (k_reg == '0);
            tbn_pkg::C_K_GT_R: cond_true = (k_reg > rounds);
            tbn_pkg::C_WIN:    cond_true = (role == tbn_pkg::ROLE_WINNER);
            tbn_pkg::C_WAIT:   cond_true = (role == tbn_pkg::ROLE_WINNER) ||
                                           (role == tbn_pkg::ROLE_CHAMPION);
            tbn_pkg::C_LOSE:   cond_true = (role == tbn_pkg::ROLE_LOSER);
            tbn_pkg::C_CHAMP:  cond_true = (k_reg != '0) && (role == tbn_pkg::ROLE_CHAMPION);
            default:           cond_true = 1'b0;
        endcase
    end

    // Dispatch a new word, else advance the program
    always_comb begin
        upc_next = upc_reg;
        k_next   = k_reg;
        if (upc_reg == tbn_pkg::U_IDLE) begin
            if (accept) begin
                if (s_mode == tbn_pkg::MODE_ARRIVE) begin
                    if (busy) begin
                        upc_next = tbn_pkg::U_ERROR;
                    end else begin
                        upc_next = tbn_pkg::U_CLIMB;
                        k_next   = KW'(1);
                    end
                end else if (!busy || s_source_node != exp_reg) begin
                    upc_next = tbn_pkg::U_ERROR;
                end else if (phase_reg == tbn_pkg::PH_WAKEUP) begin
                    upc_next = tbn_pkg::U_DESC;
                    k_next   = KW'(round_dec);
                end else begin
                    upc_next = tbn_pkg::U_ARRMSG;
                    k_next   = KW'(round_reg);
                end
            end
        end else if (step_go) begin
            case (uw.kop)
                tbn_pkg::K_INC:    k_next = k_reg + KW'(1);
                tbn_pkg::K_DEC:    k_next = k_reg - KW'(1);
                tbn_pkg::K_LOAD_R: k_next = rounds;
                default:           k_next = k_reg;
            endcase
            if (uw.done) begin
                upc_next = tbn_pkg::U_IDLE;
            end else if (cond_true) begin
                upc_next = uw.target;
            end else begin
                upc_next = upc_reg + tbn_pkg::UPC_W'(1);
            end
        end
    end

    // Update barrier state on the parking, losing and release steps
    always_comb begin
        phase_next = phase_reg;
        round_next = round_reg;
        exp_next   = exp_reg;
        if (upc_reg != tbn_pkg::U_IDLE && step_go) begin
            case (uw.sop)
                tbn_pkg::S_PARK: begin
                    phase_next = tbn_pkg::PH_ARRIVAL;
                    round_next = k_reg[RW-1:0];
                    exp_next   = up_sum[NW-1:0];
                end
                tbn_pkg::S_LOSE: begin
                    phase_next = tbn_pkg::PH_WAKEUP;
                    round_next = k_reg[RW-1:0];
                    exp_next   = down_diff[NW-1:0];
                end
                tbn_pkg::S_CLEAR: begin
                    phase_next = tbn_pkg::PH_IDLE;
                    round_next = '0;
                    exp_next   = '0;
                end
                default: begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // Load the output register on an emitting step, drop it once taken
    always_comb begin
        out_valid_next = out_valid_reg && !m_ready;
        out_kind_next  = out_kind_reg;
        out_peer_next  = out_peer_reg;
        out_last_next  = out_last_reg;
        if (upc_reg != tbn_pkg::U_IDLE && uw.emit != tbn_pkg::E_NONE && slot_free) begin
            out_valid_next = 1'b1;
            case (uw.emit)
                tbn_pkg::E_SEND_UP: begin
                    out_kind_next = tbn_pkg::KIND_SEND;
                    out_peer_next = up_sum[NW-1:0];
                    out_last_next = 1'b0;
                end
                tbn_pkg::E_SEND_DOWN: begin
                    out_kind_next = tbn_pkg::KIND_SEND;
                    out_peer_next = down_diff[NW-1:0];
                    out_last_next = 1'b1;
                end
                tbn_pkg::E_SEND_EXP: begin
                    out_kind_next = tbn_pkg::KIND_SEND;
                    out_peer_next = exp_reg;
                    out_last_next = 1'b0;
                end
                tbn_pkg::E_RELEASE: begin
                    out_kind_next = tbn_pkg::KIND_RELEASE;
                    out_peer_next = '0;
                    out_last_next = 1'b1;
                end
                default: begin
                    out_kind_next = tbn_pkg::KIND_ERROR;
                    out_peer_next = '0;
                    out_last_next = 1'b1;
                end
            endcase
        end
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_id_reg    <= '0;
            node_count_reg <= tbn_pkg::COUNT_W'(1);
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                tbn_pkg::REG_NODE_ID:    node_id_reg    <= cfg_wdata[NW-1:0];
                tbn_pkg::REG_NODE_COUNT: node_count_reg <= cfg_wdata[tbn_pkg::COUNT_W-1:0];
                default:                 node_id_reg    <= node_id_reg;
            endcase
        end
    end

    // Control and barrier state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg       <= tbn_pkg::U_IDLE;
            k_reg         <= '0;
            phase_reg     <= tbn_pkg::PH_IDLE;
            round_reg     <= '0;
            exp_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            upc_reg       <= upc_next;
            k_reg         <= k_next;
            phase_reg     <= phase_next;
            round_reg     <= round_next;
            exp_reg       <= exp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        out_kind_reg <= out_kind_next;
        out_peer_reg <= out_peer_next;
        out_last_reg <= out_last_next;
    end

    assign m_valid     = out_valid_reg;
    assign m_kind      = out_kind_reg;
    assign m_peer_node = out_peer_reg;
    assign m_last      = out_last_reg;

endmodule

// ===== src/tbn_checker.sv =====
// Port checker for the tournament barrier node, attached by bind.
// Depends on tbn_pkg and on the tournament_barrier_node ports.
module tbn_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [tbn_pkg::KIND_W-1:0]   m_kind,
    input logic [tbn_pkg::NODE_W-1:0]   m_peer_node,
    input logic                         m_last
);

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_peer_node)
        && $stable(m_last))
        else $error("result word changed while stalled");

    // Release and error carry no peer
    a_no_peer: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == tbn_pkg::KIND_RELEASE || m_kind == tbn_pkg::KIND_ERROR)
        |-> m_peer_node == '0)
        else $error("release or error word with nonzero peer");

    // Release and error always close the sequence
    a_close: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == tbn_pkg::KIND_RELEASE || m_kind == tbn_pkg::KIND_ERROR)
        |-> m_last)
        else $error("release or error word not marked last");

    // Come out of reset idle and empty
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> s_ready && !m_valid)
        else $error("node not idle after reset");

endmodule

bind tournament_barrier_node tbn_checker u_tbn_checker (.*);
